// ----- design/efhc_pkg.sv -----
// Package: shared types, codes and byte positions for the Ethernet header classifier.
`timescale 1ns / 1ps
package efhc_pkg;

  localparam int PosW = 6;

  localparam logic [PosW-1:0] POS_TYPE_HI   = 6'd12;
  localparam logic [PosW-1:0] POS_TYPE_LO   = 6'd13;
  localparam logic [PosW-1:0] POS_HW_HI     = 6'd14;
  localparam logic [PosW-1:0] POS_HW_LO     = 6'd15;
  localparam logic [PosW-1:0] POS_CTRL      = 6'd16;
  localparam logic [PosW-1:0] POS_CTRL2     = 6'd17;
  localparam logic [PosW-1:0] POS_OP_HI     = 6'd20;
  localparam logic [PosW-1:0] POS_OP_LO     = 6'd21;
  localparam logic [PosW-1:0] POS_RXSUM_HI  = 6'd24;
  localparam logic [PosW-1:0] POS_RXSUM_LO  = 6'd25;
  localparam logic [PosW-1:0] POS_SIP_FIRST = 6'd28;
  localparam logic [PosW-1:0] POS_SIP_LAST  = 6'd31;
  localparam logic [PosW-1:0] POS_TIP_FIRST = 6'd38;
  localparam logic [PosW-1:0] POS_TIP_LAST  = 6'd41;
  localparam logic [PosW-1:0] POS_SUM_FIRST = 6'd14;
  localparam logic [PosW-1:0] POS_SUM_LAST  = 6'd33;
  localparam logic [PosW-1:0] POS_MAX       = 6'd63;

  // last byte index a frame of each kind must reach
  localparam logic [PosW-1:0] LAST_ETH  = 6'd13;
  localparam logic [PosW-1:0] LAST_LLC  = 6'd17;
  localparam logic [PosW-1:0] LAST_IPV4 = 6'd33;
  localparam logic [PosW-1:0] LAST_ARP  = 6'd41;

  localparam logic [15:0] LLC_LEN_LIMIT = 16'd1500;
  localparam logic [15:0] ETYPE_IPV4    = 16'h0800;
  localparam logic [15:0] ETYPE_ARP     = 16'h0806;
  localparam logic [15:0] ARP_HW_ETH    = 16'd1;
  localparam logic [15:0] ARP_HW_IEEE   = 16'd6;
  localparam logic [15:0] ARP_OP_REQ    = 16'd1;
  localparam logic [15:0] ARP_OP_REPLY  = 16'd2;

  localparam logic [1:0] KIND_LLC     = 2'd0;
  localparam logic [1:0] KIND_IPV4    = 2'd1;
  localparam logic [1:0] KIND_ARP     = 2'd2;
  localparam logic [1:0] KIND_UNKNOWN = 2'd3;

  localparam logic [1:0] CSUM_MATCH  = 2'd0;
  localparam logic [1:0] CSUM_ZERO   = 2'd1;
  localparam logic [1:0] CSUM_BAD    = 2'd2;
  localparam logic [1:0] CSUM_NONE   = 2'd3;

  localparam logic [1:0] LLC_I    = 2'd0;
  localparam logic [1:0] LLC_S    = 2'd1;
  localparam logic [1:0] LLC_U    = 2'd2;
  localparam logic [1:0] LLC_NONE = 2'd3;

  localparam logic [1:0] ARP_HW_CODE_ETH   = 2'd0;
  localparam logic [1:0] ARP_HW_CODE_IEEE  = 2'd1;
  localparam logic [1:0] ARP_HW_CODE_OTHER = 2'd2;
  localparam logic [1:0] ARP_OP_CODE_REQ   = 2'd0;
  localparam logic [1:0] ARP_OP_CODE_REPLY = 2'd1;
  localparam logic [1:0] ARP_OP_CODE_OTHER = 2'd2;

  localparam int OutDataW = 128;

  typedef struct packed {
    logic [1:0]  frame_kind;
    logic [15:0] type_length;
    logic        truncated;
    logic [1:0]  checksum_status;
    logic [15:0] checksum_value;
    logic [1:0]  llc_class;
    logic [6:0]  llc_field_a;
    logic [6:0]  llc_receive_number;
    logic        poll_final;
    logic [4:0]  arp_kinds;
    logic [31:0] sender_ip;
    logic [31:0] target_ip;
  } efhc_res_t;

endpackage

// ----- design/efhc_parse.sv -----
// Byte-position parser: captures header fields, sums the IPv4 header and forms the result.
`timescale 1ns / 1ps
module efhc_parse
  import efhc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      take,
  input  logic [7:0] byte_in,
  input  logic      last_in,
  output efhc_res_t res
);

  logic [PosW-1:0] pos_r, pos_nxt;
  logic [15:0] type_r, type_nxt, type_ab;
  logic [15:0] sum_r, sum_nxt, sum_ab;
  logic [7:0]  hold_r, hold_nxt, hold_ab;
  logic [15:0] rxsum_r, rxsum_nxt, rxsum_ab;
  logic [7:0]  ctrl_r, ctrl_nxt, ctrl_ab;
  logic [7:0]  ctrl2_r, ctrl2_nxt, ctrl2_ab;
  logic [15:0] hw_r, hw_nxt, hw_ab;
  logic [15:0] op_r, op_nxt, op_ab;
  logic [31:0] sip_r, sip_nxt, sip_ab;
  logic [31:0] tip_r, tip_nxt, tip_ab;

  logic [7:0]  sum_byte;
  logic [16:0] sum_wide;
  logic [15:0] sum_wrap;
  logic        in_sum;
  logic [15:0] csum;
  logic [1:0]  hw_code;
  logic [1:0]  op_code;

  // absorb the byte at the current position
  always_comb begin
    in_sum   = (pos_r >= POS_SUM_FIRST) && (pos_r <= POS_SUM_LAST);
    sum_byte = ((pos_r == POS_RXSUM_HI) || (pos_r == POS_RXSUM_LO)) ? 8'd0 : byte_in;
    sum_wide = {1'b0, sum_r} + {1'b0, hold_r, sum_byte};
    sum_wrap = sum_wide[15:0] + {15'd0, sum_wide[16]};

    type_ab  = (pos_r == POS_TYPE_HI || pos_r == POS_TYPE_LO) ? {type_r[7:0], byte_in} : type_r;
    hw_ab    = (pos_r == POS_HW_HI || pos_r == POS_HW_LO) ? {hw_r[7:0], byte_in} : hw_r;
    ctrl_ab  = (pos_r == POS_CTRL) ? byte_in : ctrl_r;
    ctrl2_ab = (pos_r == POS_CTRL2) ? byte_in : ctrl2_r;
    op_ab    = (pos_r == POS_OP_HI || pos_r == POS_OP_LO) ? {op_r[7:0], byte_in} : op_r;
    rxsum_ab = (pos_r == POS_RXSUM_HI || pos_r == POS_RXSUM_LO) ?
               {rxsum_r[7:0], byte_in} : rxsum_r;
    sip_ab   = (pos_r >= POS_SIP_FIRST && pos_r <= POS_SIP_LAST) ?
               {sip_r[23:0], byte_in} : sip_r;
    tip_ab   = (pos_r >= POS_TIP_FIRST && pos_r <= POS_TIP_LAST) ?
               {tip_r[23:0], byte_in} : tip_r;
    hold_ab  = (in_sum && !pos_r[0]) ? sum_byte : hold_r;
    sum_ab   = (in_sum && pos_r[0]) ? sum_wrap : sum_r;
  end

  // advance, or drop all state after the final byte
  always_comb begin
    pos_nxt   = pos_r;
    type_nxt  = type_r;
    sum_nxt   = sum_r;
    hold_nxt  = hold_r;
    rxsum_nxt = rxsum_r;
    ctrl_nxt  = ctrl_r;
    ctrl2_nxt = ctrl2_r;
    hw_nxt    = hw_r;
    op_nxt    = op_r;
    sip_nxt   = sip_r;
    tip_nxt   = tip_r;
    if (take) begin
      if (last_in) begin
        pos_nxt   = '0;
        type_nxt  = '0;
        sum_nxt   = '0;
        hold_nxt  = '0;
        rxsum_nxt = '0;
        ctrl_nxt  = '0;
        ctrl2_nxt = '0;
        hw_nxt    = '0;
        op_nxt    = '0;
        sip_nxt   = '0;
        tip_nxt   = '0;
      end else begin
        pos_nxt   = (pos_r == POS_MAX) ? pos_r : pos_r + 6'd1;
        type_nxt  = type_ab;
        sum_nxt   = sum_ab;
        hold_nxt  = hold_ab;
        rxsum_nxt = rxsum_ab;
        ctrl_nxt  = ctrl_ab;
        ctrl2_nxt = ctrl2_ab;
        hw_nxt    = hw_ab;
        op_nxt    = op_ab;
        sip_nxt   = sip_ab;
        tip_nxt   = tip_ab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      type_r  <= '0;
      sum_r   <= '0;
      hold_r  <= '0;
      rxsum_r <= '0;
      ctrl_r  <= '0;
      ctrl2_r <= '0;
      hw_r    <= '0;
      op_r    <= '0;
      sip_r   <= '0;
      tip_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      type_r  <= type_nxt;
      sum_r   <= sum_nxt;
      hold_r  <= hold_nxt;
      rxsum_r <= rxsum_nxt;
      ctrl_r  <= ctrl_nxt;
      ctrl2_r <= ctrl2_nxt;
      hw_r    <= hw_nxt;
      op_r    <= op_nxt;
      sip_r   <= sip_nxt;
      tip_r   <= tip_nxt;
    end
  end

  // result for a frame ending at the current byte
  always_comb begin
    csum    = ~sum_ab;
    hw_code = (hw_ab == ARP_HW_ETH) ? ARP_HW_CODE_ETH :
              (hw_ab == ARP_HW_IEEE) ? ARP_HW_CODE_IEEE : ARP_HW_CODE_OTHER;
    op_code = (op_ab == ARP_OP_REQ) ? ARP_OP_CODE_REQ :
              (op_ab == ARP_OP_REPLY) ? ARP_OP_CODE_REPLY : ARP_OP_CODE_OTHER;

    res                 = '0;
    res.frame_kind      = KIND_UNKNOWN;
    res.checksum_status = CSUM_NONE;
    res.llc_class       = LLC_NONE;

    if (pos_r < LAST_ETH) begin
      res.truncated = 1'b1;
    end else begin
      res.type_length = type_ab;
      if (type_ab < LLC_LEN_LIMIT) begin
        res.frame_kind = KIND_LLC;
        if (pos_r < LAST_LLC) begin
          res.truncated = 1'b1;
        end else begin
          res.poll_final = ctrl2_ab[0];
          if (!ctrl_ab[0]) begin
            res.llc_class          = LLC_I;
            res.llc_field_a        = ctrl_ab[7:1];
            res.llc_receive_number = ctrl2_ab[7:1];
          end else if (!ctrl_ab[1]) begin
            res.llc_class   = LLC_S;
            res.llc_field_a = {5'd0, ctrl_ab[3:2]};
          end else begin
            res.llc_class = LLC_U;
          end
        end
      end else if (type_ab == ETYPE_IPV4) begin
        res.frame_kind = KIND_IPV4;
        if (pos_r < LAST_IPV4) begin
          res.truncated = 1'b1;
        end else begin
          res.checksum_value = csum;
          if (rxsum_ab == csum) begin
            res.checksum_status = CSUM_MATCH;
          end else if (rxsum_ab == 16'd0) begin
            res.checksum_status = CSUM_ZERO;
          end else begin
            res.checksum_status = CSUM_BAD;
          end
        end
      end else if (type_ab == ETYPE_ARP) begin
        res.frame_kind = KIND_ARP;
        if (pos_r < LAST_ARP) begin
          res.truncated = 1'b1;
        end else begin
          res.arp_kinds = {({ctrl_ab, ctrl2_ab} == ETYPE_IPV4), op_code, hw_code};
          res.sender_ip = sip_ab;
          res.target_ip = tip_ab;
        end
      end
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    take && last_in |=> pos_r == '0 && sum_r == '0 && type_r == '0)
    else $error("parse state not cleared after final byte");

  a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
    take && !last_in && pos_r == POS_MAX |=> pos_r == POS_MAX)
    else $error("byte position wrapped");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !take |=> $stable(pos_r) && $stable(sum_r))
    else $error("parse state moved without a byte");

endmodule

// ----- design/ethernet_frame_header_classifier_top.sv -----
// Top level: byte stream in, one header classification per frame out.
//
//   channel | dir | tdata                    | tuser      | tlast
//   in_     | in  | data_byte [7:0]          | -          | frame_end
//   out_    | out | result fields (128 bits) | frame_kind | -
//
// One byte is taken every cycle unless a final byte waits on a stalled result; a
// result follows its final byte through the input register, then the result register.
// The parser itself is one registered pass per byte, set by the checksum add.
// rst_n is synchronous: it empties both registers and clears the parse state.
// A stalled result only holds a final byte in the input register; other bytes
// keep flowing while the result waits.
`timescale 1ns / 1ps
module ethernet_frame_header_classifier_top
  import efhc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,   // [7:0] data_byte
  input  logic                in_tlast,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OutDataW-1:0] out_tdata,  // type_length, truncated, checksum_status,
                                          // checksum_value, llc_class, llc_field_a,
                                          // llc_receive_number, poll_final, arp_kinds,
                                          // sender_ip, target_ip, zero pad
  output logic [1:0]          out_tuser   // [1:0] frame_kind
);

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  efhc_res_t  out_res_r;
  efhc_res_t  res;
  logic       out_free;
  logic       s1_take;
  logic       in_fire;

  assign out_free      = !out_valid_r || out_tready;
  assign s1_take       = s1_valid_r && (!s1_last_r || out_free);
  assign in_tready     = !s1_valid_r || s1_take;
  assign in_fire       = in_tvalid && in_tready;
  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_take);
  assign out_valid_nxt = (s1_take && s1_last_r) || (out_valid_r && !out_tready);

  efhc_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (s1_take),
    .byte_in (s1_byte_r),
    .last_in (s1_last_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_tdata;
      s1_last_r <= in_tlast;
    end
    if (s1_take && s1_last_r) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.frame_kind;
  assign out_tdata  = {7'd0,
                       out_res_r.target_ip,
                       out_res_r.sender_ip,
                       out_res_r.arp_kinds,
                       out_res_r.poll_final,
                       out_res_r.llc_receive_number,
                       out_res_r.llc_field_a,
                       out_res_r.llc_class,
                       out_res_r.checksum_value,
                       out_res_r.checksum_status,
                       out_res_r.truncated,
                       out_res_r.type_length};

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !(s1_take && s1_last_r))
    else $error("pending result overwritten");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_take && s1_last_r |=> out_valid_r)
    else $error("final byte gave no result");

  a_trunc_ipv4: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.truncated |->
      out_res_r.checksum_status == CSUM_NONE && out_res_r.arp_kinds == 5'd0)
    else $error("truncated frame carries checksum or ARP fields");

  a_only_final: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r && !(s1_valid_r && s1_last_r) |=> !out_valid_r)
    else $error("result without a final byte");

endmodule

// ----- sim/tb_ethernet_frame_header_classifier_top.sv -----
// Testbench: random and directed Ethernet frames checked against a cycle-free header predictor.
`timescale 1ns / 1ps
module tb_ethernet_frame_header_classifier_top;
  import efhc_pkg::*;

  localparam int RandBytes = 1240;
  localparam int CalmBytes = 200;
  localparam int CycleLimit = 200000;
  localparam int LongHold = 300;
  localparam int HoldAfter = 400;
  localparam int DrainCycles = 10;

  typedef enum logic [1:0] {CS_GOOD, CS_ZERO, CS_BAD, CS_KEEP} csum_fill_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
  } req_t;

  logic                clk;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  logic [7:0]          in_tdata = '0;
  logic                in_tlast = 1'b0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  logic [OutDataW-1:0] out_tdata;
  logic [1:0]          out_tuser;

  req_t       req_q[$];
  efhc_res_t  header_q[$];
  logic [7:0] frm[$];
  int         n_sent = 0;
  int         n_total = 0;
  int         n_err = 0;
  int         n_cyc = 0;
  int         snd_gap = 0;
  int         rcv_gap = 0;
  int         hold_left = 0;
  bit         held_once = 1'b0;

  // parser state of the predictor
  logic [PosW-1:0] pos_r;
  logic [15:0]     etype_r, sum_r, rxsum_r, hwtype_r, oper_r;
  logic [7:0]      hi_r, ctl_r, ctl2_r;
  logic [31:0]     sip_r, tip_r;

  ethernet_frame_header_classifier_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic clear_parser();
    pos_r = '0; etype_r = '0; sum_r = '0; rxsum_r = '0; hwtype_r = '0; oper_r = '0;
    hi_r = '0; ctl_r = '0; ctl2_r = '0; sip_r = '0; tip_r = '0;
  endtask

  task automatic parse_byte(input logic [7:0] b, input logic last);
    logic [PosW-1:0] p;
    logic [7:0]      v;
    logic [16:0]     s;
    logic [1:0]      hw_code, op_code;
    efhc_res_t       r;
    p = pos_r;
    if (p == POS_TYPE_HI || p == POS_TYPE_LO) etype_r = {etype_r[7:0], b};
    if (p == POS_HW_HI || p == POS_HW_LO) hwtype_r = {hwtype_r[7:0], b};
    if (p == POS_CTRL) ctl_r = b;
    if (p == POS_CTRL2) ctl2_r = b;
    if (p == POS_OP_HI || p == POS_OP_LO) oper_r = {oper_r[7:0], b};
    if (p == POS_RXSUM_HI || p == POS_RXSUM_LO) rxsum_r = {rxsum_r[7:0], b};
    if (p >= POS_SIP_FIRST && p <= POS_SIP_LAST) sip_r = {sip_r[23:0], b};
    if (p >= POS_TIP_FIRST && p <= POS_TIP_LAST) tip_r = {tip_r[23:0], b};
    if (p >= POS_SUM_FIRST && p <= POS_SUM_LAST) begin
      v = (p == POS_RXSUM_HI || p == POS_RXSUM_LO) ? 8'h00 : b;
      if (!p[0]) begin
        hi_r = v;
      end else begin
        s = {1'b0, sum_r} + {1'b0, hi_r, v};
        sum_r = s[15:0] + 16'(s[16]);
      end
    end
    if (pos_r != POS_MAX) pos_r = pos_r + 1'b1;
    if (!last) return;

    r = '0;
    r.frame_kind = KIND_UNKNOWN;
    r.checksum_status = CSUM_NONE;
    r.llc_class = LLC_NONE;
    if (p < LAST_ETH) begin
      r.truncated = 1'b1;
    end else begin
      r.type_length = etype_r;
      if (etype_r < LLC_LEN_LIMIT) begin
        r.frame_kind = KIND_LLC;
        if (p < LAST_LLC) begin
          r.truncated = 1'b1;
        end else begin
          r.poll_final = ctl2_r[0];
          if (!ctl_r[0]) begin
            r.llc_class = LLC_I;
            r.llc_field_a = ctl_r[7:1];
            r.llc_receive_number = ctl2_r[7:1];
          end else if (!ctl_r[1]) begin
            r.llc_class = LLC_S;
            r.llc_field_a = 7'(ctl_r[3:2]);
          end else begin
            r.llc_class = LLC_U;
          end
        end
      end else if (etype_r == ETYPE_IPV4) begin
        r.frame_kind = KIND_IPV4;
        if (p < LAST_IPV4) begin
          r.truncated = 1'b1;
        end else begin
          r.checksum_value = ~sum_r;
          if (rxsum_r == ~sum_r) r.checksum_status = CSUM_MATCH;
          else if (rxsum_r == 16'h0000) r.checksum_status = CSUM_ZERO;
          else r.checksum_status = CSUM_BAD;
        end
      end else if (etype_r == ETYPE_ARP) begin
        r.frame_kind = KIND_ARP;
        if (p < LAST_ARP) begin
          r.truncated = 1'b1;
        end else begin
          hw_code = (hwtype_r == ARP_HW_ETH) ? ARP_HW_CODE_ETH :
                    (hwtype_r == ARP_HW_IEEE) ? ARP_HW_CODE_IEEE : ARP_HW_CODE_OTHER;
          op_code = (oper_r == ARP_OP_REQ) ? ARP_OP_CODE_REQ :
                    (oper_r == ARP_OP_REPLY) ? ARP_OP_CODE_REPLY : ARP_OP_CODE_OTHER;
          r.arp_kinds = {({ctl_r, ctl2_r} == ETYPE_IPV4), op_code, hw_code};
          r.sender_ip = sip_r;
          r.target_ip = tip_r;
        end
      end
    end
    header_q.push_back(r);
    clear_parser();
  endtask

  // frame construction
  task automatic put(input int pos, input logic [7:0] val);
    if (pos < frm.size()) frm[pos] = val;
  endtask

  task automatic put16(input int pos, input logic [15:0] val);
    put(pos, val[15:8]);
    put(pos + 1, val[7:0]);
  endtask

  task automatic begin_frame(input int len, input logic [15:0] tl, input int fill);
    frm.delete();
    for (int i = 0; i < len; i++) frm.push_back((fill < 0) ? 8'($urandom) : 8'(fill));
    put16(int'(POS_TYPE_HI), tl);
  endtask

  function automatic logic [15:0] header_csum();
    logic [16:0] s;
    logic [15:0] acc;
    acc = '0;
    for (int i = int'(POS_SUM_FIRST); i <= int'(POS_SUM_LAST); i += 2) begin
      if (i != int'(POS_RXSUM_HI) && i + 1 < frm.size()) begin
        s = {1'b0, acc} + {1'b0, frm[i], frm[i+1]};
        acc = s[15:0] + 16'(s[16]);
      end
    end
    return ~acc;
  endfunction

  task automatic place_csum(input csum_fill_t how);
    case (how)
      CS_GOOD: put16(int'(POS_RXSUM_HI), header_csum());
      CS_ZERO: put16(int'(POS_RXSUM_HI), 16'h0000);
      CS_BAD:  put16(int'(POS_RXSUM_HI), header_csum() ^ 16'h0100);
      default: ;
    endcase
  endtask

  task automatic arp_fields(input logic [15:0] hw, input logic [15:0] proto,
                            input logic [15:0] op);
    put16(int'(POS_HW_HI), hw);
    put16(int'(POS_CTRL), proto);
    put16(int'(POS_OP_HI), op);
  endtask

  task automatic send_frame();
    req_t rq;
    foreach (frm[i]) begin
      rq.data = frm[i];
      rq.last = (i == frm.size() - 1);
      req_q.push_back(rq);
    end
    frm.delete();
  endtask

  function automatic int pick_len(input int need);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return $urandom_range(LAST_ETH + 1, need - 1);
    if (r == 1) return $urandom_range(need, 72);
    return need + $urandom_range(0, 4);
  endfunction

  function automatic logic [15:0] pick_word(input logic [15:0] a, input logic [15:0] b);
    int r;
    r = $urandom_range(0, 2);
    return (r == 0) ? a : (r == 1) ? b : 16'($urandom);
  endfunction

  task automatic rand_frame();
    int         sel;
    logic [15:0] tl;
    sel = $urandom_range(0, 9);
    if (sel <= 2) begin
      begin_frame(pick_len(LAST_IPV4 + 1), ETYPE_IPV4, -1);
      place_csum(csum_fill_t'($urandom_range(0, 3)));
    end else if (sel <= 4) begin
      begin_frame(pick_len(LAST_ARP + 1), ETYPE_ARP, -1);
      arp_fields(pick_word(ARP_HW_ETH, ARP_HW_IEEE),
                 ($urandom_range(0, 3) != 0) ? ETYPE_IPV4 : 16'($urandom),
                 pick_word(ARP_OP_REQ, ARP_OP_REPLY));
    end else if (sel <= 6) begin
      begin_frame(pick_len(LAST_LLC + 1), 16'($urandom_range(0, LLC_LEN_LIMIT - 1)), -1);
    end else if (sel == 7) begin
      tl = 16'($urandom_range(LLC_LEN_LIMIT, 16'hFFFF));
      begin_frame(pick_len(LAST_ETH + 1), tl, -1);
    end else if (sel == 8) begin
      begin_frame($urandom_range(1, LAST_ETH), 16'($urandom), -1);
    end else begin
      begin_frame($urandom_range(1, 72), 16'($urandom), -1);
    end
    send_frame();
  endtask

  task automatic build_stimulus();
    begin_frame(1, 16'h0000, -1); send_frame();
    begin_frame(int'(LAST_ETH), 16'hFFFF, 'hFF); send_frame();
    begin_frame(LAST_ETH + 1, LLC_LEN_LIMIT - 16'd1, -1); send_frame();
    begin_frame(LAST_LLC + 1, 16'h0000, 'hFF); put(int'(POS_CTRL), 8'hFE); send_frame();
    begin_frame(LAST_LLC + 1, LLC_LEN_LIMIT - 16'd1, 'h00); put(int'(POS_CTRL), 8'h0D);
    put(int'(POS_CTRL2), 8'h01); send_frame();
    begin_frame(LAST_LLC + 3, 16'd20, -1); put(int'(POS_CTRL), 8'h03); send_frame();
    begin_frame(LAST_ETH + 1, LLC_LEN_LIMIT, -1); send_frame();
    begin_frame(20, 16'hFFFF, 'h00); send_frame();
    begin_frame(LAST_IPV4 + 1, ETYPE_IPV4, 'hFF); place_csum(CS_GOOD); send_frame();
    begin_frame(LAST_IPV4 + 1, ETYPE_IPV4, 'h11); place_csum(CS_ZERO); send_frame();
    begin_frame(LAST_IPV4 + 1, ETYPE_IPV4, 'h11); place_csum(CS_BAD); send_frame();
    // all-ones sum: computed checksum is zero and so is the received one
    begin_frame(LAST_IPV4 + 1, ETYPE_IPV4, 'h00); put16(int'(POS_HW_HI), 16'hFFFF);
    send_frame();
    begin_frame(int'(LAST_IPV4), ETYPE_IPV4, -1); send_frame();
    begin_frame(LAST_ARP + 1, ETYPE_ARP, -1); arp_fields(ARP_HW_ETH, ETYPE_IPV4, ARP_OP_REQ);
    send_frame();
    begin_frame(LAST_ARP + 1, ETYPE_ARP, 'hFF);
    arp_fields(ARP_HW_IEEE, 16'h86DD, ARP_OP_REPLY); send_frame();
    begin_frame(70, ETYPE_ARP, -1); arp_fields(16'h0000, ETYPE_IPV4, 16'hFFFF); send_frame();
    begin_frame(int'(LAST_ARP), ETYPE_ARP, -1);
    arp_fields(ARP_HW_ETH, ETYPE_IPV4, ARP_OP_REQ);
    send_frame();
    begin_frame(80, 16'd46, -1); send_frame();
    n_total = req_q.size() + RandBytes;
    while (req_q.size() < n_total) rand_frame();
    n_total = req_q.size();
  endtask

  // sender
  always @(posedge clk) begin
    req_t rq;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tlast);
        n_sent <= n_sent + 1;
      end
      if (!in_tvalid || in_tready) begin
        if (snd_gap > 0) begin
          snd_gap--;
          in_tvalid <= 1'b0;
        end else if (req_q.size() > 0) begin
          rq = req_q.pop_front();
          in_tdata <= rq.data;
          in_tlast <= rq.last;
          in_tvalid <= 1'b1;
          if (req_q.size() > CalmBytes && $urandom_range(0, 9) == 0)
            snd_gap = $urandom_range(1, 5);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!held_once && n_sent >= HoldAfter) begin
      held_once = 1'b1;
      hold_left = LongHold - 1;
      out_tready <= 1'b0;
    end else if (rcv_gap > 0) begin
      rcv_gap--;
      out_tready <= 1'b0;
    end else if (n_sent < n_total - CalmBytes && $urandom_range(0, 7) == 0) begin
      rcv_gap = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      n_err++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    efhc_res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (header_q.size() == 0) begin
        $error("result with no frame outstanding: tuser 0x%0h tdata 0x%0h",
               out_tuser, out_tdata);
        n_err++;
      end else begin
        e = header_q.pop_front();
        check_field("frame_kind", 32'(e.frame_kind), 32'(out_tuser));
        check_field("type_length", 32'(e.type_length), 32'(out_tdata[15:0]));
        check_field("truncated", 32'(e.truncated), 32'(out_tdata[16]));
        check_field("checksum_status", 32'(e.checksum_status), 32'(out_tdata[18:17]));
        check_field("checksum_value", 32'(e.checksum_value), 32'(out_tdata[34:19]));
        check_field("llc_class", 32'(e.llc_class), 32'(out_tdata[36:35]));
        check_field("llc_field_a", 32'(e.llc_field_a), 32'(out_tdata[43:37]));
        check_field("llc_receive_number", 32'(e.llc_receive_number),
                    32'(out_tdata[50:44]));
        check_field("poll_final", 32'(e.poll_final), 32'(out_tdata[51]));
        check_field("arp_kinds", 32'(e.arp_kinds), 32'(out_tdata[56:52]));
        check_field("sender_ip", e.sender_ip, out_tdata[88:57]);
        check_field("target_ip", e.target_ip, out_tdata[120:89]);
        check_field("pad", 32'h0, 32'(out_tdata[127:121]));
      end
    end
  end

  always @(posedge clk) begin
    n_cyc <= n_cyc + 1;
    if (n_cyc == CycleLimit) begin
      $display("tb_ethernet_frame_header_classifier_top: FAIL");
      $finish;
    end
  end

  initial begin
    clear_parser();
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    while (req_q.size() != 0 || in_tvalid || header_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (n_err == 0) begin
      $display("tb_ethernet_frame_header_classifier_top: PASS");
    end else begin
      $display("tb_ethernet_frame_header_classifier_top: FAIL");
    end
    $finish;
  end

endmodule

// ----- ethernet_frame_header_classifier_top.f -----
design/efhc_pkg.sv
design/efhc_parse.sv
design/ethernet_frame_header_classifier_top.sv
sim/tb_ethernet_frame_header_classifier_top.sv
